@@ design/dhs_pkg.sv @@
// Package for the detection head sigmoid stream unit: widths, register codes,
// the position struct and the elaboration-time builder of the sigmoid table.
// No dependencies.
`timescale 1ns / 1ps

package dhs_pkg;

  localparam int TABLE_ENTRIES = 2048;
  localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
  localparam int DATA_W        = 16;
  localparam int PLANE_W       = 17;
  localparam int CLASS_W       = 8;
  localparam int ANCHOR_W      = 4;
  localparam int PIXEL_W       = 16;
  localparam int CHAN_W        = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;
  // Magnitude of the table argument, wide enough for 2048 and any table index.
  localparam int MAG_W         = 14;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_COUNT = 2'd2;

  localparam logic [PLANE_W-1:0]  PLANE_RESET  = 17'd169;
  localparam logic [CLASS_W-1:0]  CLASS_RESET  = 8'd80;
  localparam logic [ANCHOR_W-1:0] ANCHOR_RESET = 4'd3;

  localparam logic [DATA_W-1:0] SIG_ONE = 16'd4096;

  typedef struct packed {
    logic [ANCHOR_W-1:0] anchor;
    logic [CHAN_W-1:0]   channel;
    logic [PIXEL_W-1:0]  pixel;
    logic                act;
  } pos_t;

  typedef logic [DATA_W-1:0] sig_tab_t [TABLE_ENTRIES];

  // Restoring division, used only while the table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q62 product: (a * b) >> 62, by shift and add.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] acc;
    acc = '0;
    for (int j = 0; j < 64; j++) begin
      if (b[j]) begin
        acc = acc + ({64'd0, a} << j);
      end
    end
    return acc[125:62];
  endfunction

  // tab[k] = round(4096 / (1 + exp(-k/256))), all in integer arithmetic.
  function automatic sig_tab_t build_sig_tab();
    logic [63:0] one;
    logic [63:0] c;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    sig_tab_t    t;
    one  = 64'h4000_0000_0000_0000;
    c    = one;
    term = one;
    e    = one;
    // Taylor series of exp(-1/256); the terms reach zero long before the bound.
    for (int k = 1; k < 32; k++) begin
      term = udiv64(term, 64'(256 * k));
      if (k[0]) begin
        c = c - term;
      end else begin
        c = c + term;
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      d    = (64'd1 << 40) + (e >> 22);
      t[i] = 16'(udiv64((64'd1 << 52) + (d >> 1), d));
      e    = mul_q62(e, c);
    end
    return t;
  endfunction

endpackage

@@ design/dhs_pos_track.sv @@
// Configuration registers and the pixel, channel and anchor position counters.
// Depends on dhs_pkg.
`timescale 1ns / 1ps

module dhs_pos_track (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               beat,
  input  logic                               last,
  output dhs_pkg::pos_t                      pos
);

  logic [dhs_pkg::PLANE_W-1:0]  plane_size;
  logic [dhs_pkg::CLASS_W-1:0]  class_count;
  logic [dhs_pkg::ANCHOR_W-1:0] anchor_count;

  logic [dhs_pkg::PIXEL_W-1:0]  pixel;
  logic [dhs_pkg::CHAN_W-1:0]   channel;
  logic [dhs_pkg::ANCHOR_W-1:0] anchor;
  logic [dhs_pkg::PIXEL_W-1:0]  pixel_next;
  logic [dhs_pkg::CHAN_W-1:0]   channel_next;
  logic [dhs_pkg::ANCHOR_W-1:0] anchor_next;

  logic [dhs_pkg::PLANE_W-1:0]  plane_eff;
  logic [dhs_pkg::PLANE_W-1:0]  pixel_inc;
  logic [dhs_pkg::CHAN_W-1:0]   group;
  logic [dhs_pkg::CHAN_W-1:0]   channel_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_size   <= dhs_pkg::PLANE_RESET;
      class_count  <= dhs_pkg::CLASS_RESET;
      anchor_count <= dhs_pkg::ANCHOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dhs_pkg::REG_PLANE_SIZE:   plane_size   <= cfg_data;
        dhs_pkg::REG_CLASS_COUNT:  class_count  <= cfg_data[dhs_pkg::CLASS_W-1:0];
        dhs_pkg::REG_ANCHOR_COUNT: anchor_count <= cfg_data[dhs_pkg::ANCHOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // A plane of zero pixels counts as one; plane sizes above 65536 count as 65536.
    if (plane_size == '0) begin
      plane_eff = 17'd1;
    end else if (plane_size[16] && (plane_size[15:0] != '0)) begin
      plane_eff = 17'h10000;
    end else begin
      plane_eff = plane_size;
    end
    pixel_inc   = {1'b0, pixel} + 17'd1;
    group       = {1'b0, class_count} + 9'd5;
    channel_inc = channel + 9'd1;

    pixel_next   = pixel;
    channel_next = channel;
    anchor_next  = anchor;
    if (last) begin
      pixel_next   = '0;
      channel_next = '0;
      anchor_next  = '0;
    end else if (pixel_inc >= plane_eff) begin
      pixel_next = '0;
      if (channel_inc >= group) begin
        channel_next = '0;
        if (anchor != 4'hF) begin
          anchor_next = anchor + 4'd1;
        end
      end else begin
        channel_next = channel_inc;
      end
    end else begin
      pixel_next = pixel_inc[dhs_pkg::PIXEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel   <= '0;
      channel <= '0;
      anchor  <= '0;
    end else if (beat) begin
      pixel   <= pixel_next;
      channel <= channel_next;
      anchor  <= anchor_next;
    end
  end

  always_comb begin
    pos.anchor  = anchor;
    pos.channel = channel;
    pos.pixel   = pixel;
    // Box size channels 2 and 3 pass; so does every anchor group past the count.
    pos.act     = (anchor < anchor_count) && ((channel < 9'd2) || (channel >= 9'd4));
  end

endmodule

@@ design/dhs_sig_rom.sv @@
// Sigmoid lookup ROM with a registered read port.
// Depends on dhs_pkg for the table contents and widths.
`timescale 1ns / 1ps

module dhs_sig_rom (
  input  logic                            clk,
  input  logic                            en,
  input  logic [dhs_pkg::TAB_AW-1:0]      addr,
  output logic [dhs_pkg::DATA_W-1:0]      rd
);

  localparam dhs_pkg::sig_tab_t SIG_TAB = dhs_pkg::build_sig_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      rd <= SIG_TAB[addr];
    end
  end

endmodule

@@ design/detection_head_sigmoid_stream_unit.sv @@
// Top level of the detection head sigmoid stream unit: stream ports, the
// lookup stage and the result register. Uses dhs_pkg, dhs_pos_track, dhs_sig_rom.
// Path: an accepted input beat passes the ROM read and then the result register.
// Throughput: one beat per cycle unless a held result on the master side stalls the pipe.
// Reset (rst, synchronous, active high) empties the pipe, zeroes the position
// counters and loads plane_size 169, class_count 80, anchor_count 3.
`timescale 1ns / 1ps

module detection_head_sigmoid_stream_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // [15:0] data_in
  input  logic                             s_tlast,   // last_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [15:0] data_out
  output logic                             m_tlast    // last_out
);

  dhs_pkg::pos_t pos;

  logic                          s_accept;
  logic                          adv2;
  logic                          v1;
  logic [dhs_pkg::DATA_W-1:0]    raw1;
  logic                          last1;
  logic                          act1;
  logic                          neg1;
  logic [dhs_pkg::DATA_W-1:0]    tab1;
  logic [dhs_pkg::MAG_W-1:0]     mag;
  logic [dhs_pkg::TAB_AW-1:0]    tab_addr;
  logic [dhs_pkg::DATA_W-1:0]    result;

  localparam logic [dhs_pkg::MAG_W-1:0] TAB_MAX = dhs_pkg::MAG_W'(dhs_pkg::TABLE_ENTRIES - 1);

  assign adv2     = !m_tvalid || m_tready;
  assign s_tready = !v1 || adv2;
  assign s_accept = s_tvalid && s_tready;

  dhs_pos_track u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (s_accept),
    .last      (s_tlast),
    .pos       (pos)
  );

  // The table argument is data >> 4; negative arguments use the mirrored entry.
  always_comb begin
    if (s_tdata[15]) begin
      mag = dhs_pkg::MAG_W'(14'd0 - {2'b11, s_tdata[15:4]});
    end else begin
      mag = {2'b00, s_tdata[15:4]};
    end
    if (mag > TAB_MAX) begin
      tab_addr = TAB_MAX[dhs_pkg::TAB_AW-1:0];
    end else begin
      tab_addr = mag[dhs_pkg::TAB_AW-1:0];
    end
  end

  dhs_sig_rom u_rom (
    .clk  (clk),
    .en   (s_tready),
    .addr (tab_addr),
    .rd   (tab1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (adv2) begin
        m_tvalid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      raw1  <= s_tdata;
      last1 <= s_tlast;
      act1  <= pos.act;
      neg1  <= s_tdata[15];
    end
  end

  always_comb begin
    if (!act1) begin
      result = raw1;
    end else if (neg1) begin
      result = dhs_pkg::SIG_ONE - tab1;
    end else begin
      result = tab1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      m_tdata <= result;
      m_tlast <= last1;
    end
  end

  // The input side only stalls behind a held result.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the output side could move");

  // A beat flagged last restarts the blob position.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> (pos.pixel == '0 && pos.channel == '0 && pos.anchor == '0))
    else $error("position counters not cleared after the last beat");

  // A beat in the lookup stage is never dropped while the output is held.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && m_tvalid && !m_tready) |=> v1)
    else $error("lookup stage lost a beat during a stall");

endmodule

@@ tb/detection_head_sigmoid_stream_unit_tb.sv @@
// Self-checking testbench for detection_head_sigmoid_stream_unit: directed table plus
// random blobs, scoreboarded against a local model of the position counters and sigmoid.
// Depends on dhs_pkg and the design files under design/.
`timescale 1ns / 1ps

module detection_head_sigmoid_stream_unit_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_BEATS = 1400;
  localparam int PIPE_SLACK   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_BLOB     = 600;

  localparam logic [dhs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [dhs_pkg::DATA_W-1:0] data;
    logic                       last;
  } elem_t;

  typedef struct {
    bit                           is_cfg;
    logic [dhs_pkg::PLANE_W-1:0]  plane;
    logic [dhs_pkg::CLASS_W-1:0]  classes;
    logic [dhs_pkg::ANCHOR_W-1:0] anchors;
    bit                           poke_unused;
    logic [dhs_pkg::DATA_W-1:0]   data;
    logic                         last;
    bit                           typed;
    logic [dhs_pkg::DATA_W-1:0]   want;
  } directed_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [dhs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dhs_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [15:0]                    s_tdata;   // [15:0] data_in
  logic                           s_tlast;   // last_in
  logic                           m_tvalid;
  logic                           m_tready;
  logic [15:0]                    m_tdata;   // [15:0] data_out
  logic                           m_tlast;   // last_out

  // Local copy of the block's registers and position counters.
  logic [dhs_pkg::PLANE_W-1:0]  plane_reg;
  logic [dhs_pkg::CLASS_W-1:0]  classes_reg;
  logic [dhs_pkg::ANCHOR_W-1:0] anchors_reg;
  int unsigned                  pixel_pos;
  int unsigned                  chan_pos;
  int unsigned                  anchor_pos;

  logic [dhs_pkg::DATA_W-1:0] sig_lut [dhs_pkg::TABLE_ENTRIES];

  elem_t         expected_elems [$];
  elem_t         oldest;
  directed_row_t directed_steps [$];

  int  error_count;
  int  beats_sent;
  int  beats_checked;
  int  config_count;
  int  activated_count;
  int  saturated_count;
  int  idle_mode;
  bit  hold_req;

  detection_head_sigmoid_stream_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Same integer recipe as the hardware table: exp(-1/256) in Q62 from its series,
  // powers by Q62 products, then 4096 / (1 + e) rounded half up.
  function automatic void build_sig_lut();
    longint unsigned one;
    longint unsigned c;
    longint unsigned term;
    longint unsigned e;
    longint unsigned d;
    longint unsigned k;
    logic [127:0]    prod;
    one  = 64'd1 << 62;
    c    = one;
    term = one;
    e    = one;
    k    = 1;
    while (term != 0) begin
      term = term / (64'd256 * k);
      if (k % 2 == 1) begin
        c = c - term;
      end else begin
        c = c + term;
      end
      k++;
    end
    for (int i = 0; i < dhs_pkg::TABLE_ENTRIES; i++) begin
      d          = (64'd1 << 40) + (e >> 22);
      sig_lut[i] = 16'(((64'd1 << 52) + d / 2) / d);
      prod       = {64'd0, e} * {64'd0, c};
      e          = prod[125:62];
    end
  endfunction

  function automatic logic [dhs_pkg::DATA_W-1:0] logistic_q12(
      input logic signed [dhs_pkg::DATA_W-1:0] x);
    logic signed [11:0] q;
    int                 mag;
    q   = x >>> 4;
    mag = (q < 0) ? -int'(q) : int'(q);
    if (mag > dhs_pkg::TABLE_ENTRIES - 1) begin
      mag = dhs_pkg::TABLE_ENTRIES - 1;
    end
    if (q < 0) begin
      return 16'(32'd4096 - sig_lut[mag]);
    end
    return sig_lut[mag];
  endfunction

  // Works out the output beat for one input beat and advances the position counters.
  function automatic elem_t activate_element(input logic [dhs_pkg::DATA_W-1:0] x,
                                             input logic last);
    int unsigned eff_plane;
    int unsigned group;
    bit          act;
    elem_t       res;
    eff_plane = plane_reg;
    if (eff_plane == 0) begin
      eff_plane = 1;
    end
    if (eff_plane > 65536) begin
      eff_plane = 65536;
    end
    group = classes_reg + 5;
    act   = (anchor_pos < anchors_reg) && (chan_pos < 2 || chan_pos >= 4);
    if (act) begin
      activated_count++;
    end
    if (anchor_pos == 15) begin
      saturated_count++;
    end
    res.data = act ? logistic_q12(x) : x;
    res.last = last;
    if (last) begin
      pixel_pos  = 0;
      chan_pos   = 0;
      anchor_pos = 0;
    end else if (pixel_pos + 1 >= eff_plane) begin
      pixel_pos = 0;
      if (chan_pos + 1 >= group) begin
        chan_pos = 0;
        if (anchor_pos < 15) begin
          anchor_pos++;
        end
      end else begin
        chan_pos++;
      end
    end else begin
      pixel_pos++;
    end
    return res;
  endfunction

  function automatic bit roll_pct(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int tx_idle_pct();
    return (idle_mode == 0) ? 36 : (idle_mode == 1) ? 84 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (idle_mode == 0) ? 84 : (idle_mode == 1) ? 36 : 0;
  endfunction

  function automatic logic [dhs_pkg::DATA_W-1:0] random_elem();
    logic [dhs_pkg::DATA_W-1:0] corners [4];
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    if ($urandom_range(0, 9) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return 16'($urandom);
  endfunction

  function automatic directed_row_t beat_row(input logic [dhs_pkg::DATA_W-1:0] x,
                                             input logic last, input bit typed,
                                             input logic [dhs_pkg::DATA_W-1:0] want);
    directed_row_t r;
    r        = '{default: '0};
    r.data   = x;
    r.last   = last;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic directed_row_t cfg_row(input logic [dhs_pkg::PLANE_W-1:0] p,
                                            input logic [dhs_pkg::CLASS_W-1:0] c,
                                            input logic [dhs_pkg::ANCHOR_W-1:0] a,
                                            input bit poke);
    directed_row_t r;
    r             = '{default: '0};
    r.is_cfg      = 1'b1;
    r.plane       = p;
    r.classes     = c;
    r.anchors     = a;
    r.poke_unused = poke;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [dhs_pkg::DATA_W-1:0] x, input logic last,
                           input bit typed, input logic [dhs_pkg::DATA_W-1:0] want);
    elem_t predicted;
    while (roll_pct(tx_idle_pct())) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= x;
    s_tlast   <= last;
    predicted = activate_element(x, last);
    if (typed) begin
      predicted.data = want;
    end
    expected_elems.push_back(predicted);
    beats_sent++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(negedge clk);
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  task automatic apply_config(input logic [dhs_pkg::PLANE_W-1:0] p,
                              input logic [dhs_pkg::CLASS_W-1:0] c,
                              input logic [dhs_pkg::ANCHOR_W-1:0] a, input bit poke);
    cfg_we    <= 1'b1;
    cfg_index <= dhs_pkg::REG_PLANE_SIZE;
    cfg_data  <= p;
    @(negedge clk);
    cfg_index <= dhs_pkg::REG_CLASS_COUNT;
    cfg_data  <= dhs_pkg::CFG_DATA_W'(c);
    @(negedge clk);
    cfg_index <= dhs_pkg::REG_ANCHOR_COUNT;
    cfg_data  <= dhs_pkg::CFG_DATA_W'(a);
    @(negedge clk);
    // A write to the spare index must leave every register alone.
    if (poke) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 17'(($urandom & 32'h1FFFF) | 32'h1);
      @(negedge clk);
    end
    cfg_we      <= 1'b0;
    plane_reg   = p;
    classes_reg = c;
    anchors_reg = a;
    config_count++;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= !roll_pct(rx_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_elems.size() == 0) begin
        $display("%0t: output beat with nothing expected: expected none, actual data=%h last=%b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        oldest = expected_elems.pop_front();
        beats_checked++;
        if (m_tdata !== oldest.data) begin
          $display("%0t: data_out mismatch: expected %h, actual %h", $time, oldest.data, m_tdata);
          error_count++;
        end
        if (m_tlast !== oldest.last) begin
          $display("%0t: last_out mismatch: expected %b, actual %b", $time, oldest.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned                  random_base;
    int unsigned                  eff_plane;
    int unsigned                  group;
    int unsigned                  groups_in_blob;
    int unsigned                  len;
    int unsigned                  waited;
    int                           blobs;
    int                           r;
    bit                           hold_issued;
    logic [dhs_pkg::PLANE_W-1:0]  p;
    logic [dhs_pkg::CLASS_W-1:0]  c;
    logic [dhs_pkg::ANCHOR_W-1:0] a;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    hold_req    = 1'b0;
    hold_issued = 1'b0;
    idle_mode   = 0;
    error_count = 0;
    beats_sent  = 0;
    beats_checked   = 0;
    config_count    = 0;
    activated_count = 0;
    saturated_count = 0;
    build_sig_lut();
    plane_reg   = dhs_pkg::PLANE_RESET;
    classes_reg = dhs_pkg::CLASS_RESET;
    anchors_reg = dhs_pkg::ANCHOR_RESET;
    pixel_pos   = 0;
    chan_pos    = 0;
    anchor_pos  = 0;

    // Reset defaults first: channel 0 of anchor 0 is activated, sigma(0) is one half.
    directed_steps.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'd2048));
    directed_steps.push_back(beat_row(16'h7FFF, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'h8000, 1'b1, 1'b0, '0));
    // One pixel, no classes, one anchor: walk all five channels, then a spare anchor.
    directed_steps.push_back(cfg_row(17'd1, 8'd0, 4'd1, 1'b0));
    directed_steps.push_back(beat_row(16'h1234, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'hFFFF, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'h7FFF, 1'b0, 1'b1, 16'h7FFF));
    directed_steps.push_back(beat_row(16'h8000, 1'b0, 1'b1, 16'h8000));
    directed_steps.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'd2048));
    directed_steps.push_back(beat_row(16'h5A5A, 1'b1, 1'b1, 16'h5A5A));
    // No anchors enabled: everything passes.
    directed_steps.push_back(cfg_row(17'd1, 8'd0, 4'd0, 1'b0));
    directed_steps.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'h0000));
    directed_steps.push_back(beat_row(16'hABCD, 1'b1, 1'b1, 16'hABCD));
    // Plane size zero acts as one; widest class count and anchor count.
    directed_steps.push_back(cfg_row(17'd0, 8'd255, 4'd15, 1'b0));
    directed_steps.push_back(beat_row(16'h0010, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'd2048));
    directed_steps.push_back(beat_row(16'h4321, 1'b0, 1'b1, 16'h4321));
    directed_steps.push_back(beat_row(16'h8001, 1'b0, 1'b1, 16'h8001));
    directed_steps.push_back(beat_row(16'hFFF0, 1'b1, 1'b0, '0));
    // Plane size above the counter range, and a write to the spare index.
    directed_steps.push_back(cfg_row(17'h1FFFF, 8'd80, 4'd3, 1'b1));
    directed_steps.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'd2048));
    directed_steps.push_back(beat_row(16'h7FF0, 1'b1, 1'b0, '0));
    directed_steps.push_back(cfg_row(17'd2, 8'd1, 4'd2, 1'b1));
    directed_steps.push_back(beat_row(16'h0100, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'hFF00, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'h0800, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'hF800, 1'b0, 1'b0, '0));
    directed_steps.push_back(beat_row(16'h2000, 1'b0, 1'b1, 16'h2000));
    directed_steps.push_back(beat_row(16'hE000, 1'b1, 1'b1, 16'hE000));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        drain_pipe();
        apply_config(directed_steps[i].plane, directed_steps[i].classes,
                     directed_steps[i].anchors, directed_steps[i].poke_unused);
      end else begin
        send_beat(directed_steps[i].data, directed_steps[i].last,
                  directed_steps[i].typed, directed_steps[i].want);
      end
    end

    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_BEATS) begin
      drain_pipe();
      r = $urandom_range(0, 99);
      if (r < 70)      p = 17'($urandom_range(1, 4));
      else if (r < 80) p = 17'd0;
      else if (r < 88) p = 17'($urandom_range(5, 40));
      else if (r < 94) p = 17'd65536;
      else             p = 17'($urandom_range(65537, 131071));
      r = $urandom_range(0, 99);
      if (r < 70)      c = 8'($urandom_range(0, 3));
      else if (r < 85) c = 8'($urandom_range(4, 20));
      else if (r < 93) c = 8'd255;
      else             c = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10)      a = 4'd0;
      else if (r < 20) a = 4'd15;
      else if (r < 90) a = 4'($urandom_range(1, 4));
      else             a = 4'($urandom);
      apply_config(p, c, a, $urandom_range(0, 3) == 0);

      eff_plane = (p == 0) ? 1 : (p > 65536) ? 65536 : p;
      group     = c + 5;
      blobs     = $urandom_range(1, 4);
      for (int b = 0; b < blobs && beats_sent - random_base < RANDOM_BEATS; b++) begin
        idle_mode = (beats_sent - random_base) * 3 / RANDOM_BEATS;
        if (idle_mode > 2) idle_mode = 2;
        // With no random idling the sender keeps offering while the output is held off.
        if (idle_mode == 2 && !hold_issued) begin
          hold_req    = 1'b1;
          hold_issued = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(1, 60);
          for (int i = 0; i < len; i++) begin
            send_beat(random_elem(), $urandom_range(0, 9) == 0, 1'b0, '0);
          end
        end else begin
          groups_in_blob = (a == 0) ? $urandom_range(1, 2) : a + $urandom_range(0, 1);
          // Enough anchor groups to run the anchor counter into saturation.
          if (eff_plane * group <= 20 && $urandom_range(0, 9) == 0) begin
            groups_in_blob = 17;
          end
          len = eff_plane * group * groups_in_blob;
          if (len > MAX_BLOB) begin
            len = $urandom_range(1, MAX_BLOB);
          end
          // Keep the total close to the planned number of random beats.
          if (len > RANDOM_BEATS - (beats_sent - random_base)) begin
            len = RANDOM_BEATS - (beats_sent - random_base);
          end
          for (int i = 0; i < len; i++) begin
            send_beat(random_elem(), i == len - 1, 1'b0, '0);
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_elems.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_elems.size() != 0) begin
      $display("%0t: %0d expected output beats never arrived", $time, expected_elems.size());
      error_count += expected_elems.size();
    end
    repeat (PIPE_SLACK * 2) @(posedge clk);

    $display("Sent %0d beats over %0d register settings, checked %0d output beats.",
             beats_sent, config_count, beats_checked);
    $display("Sigmoid applied to %0d beats, %0d beats seen past the anchor counter limit.",
             activated_count, saturated_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
